// File: rtl/bst_pkg.sv
`timescale 1ns / 1ps

package bst_pkg;

    localparam int CRD_W     = 16;
    localparam int MUL_W     = 27;
    localparam int PRD_W     = 2 * MUL_W;
    localparam int SQ_IN_W   = 50;
    localparam int ROOT_W    = SQ_IN_W / 2;
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 26;
    localparam int T_W       = 25;
    localparam int COEF_W    = 21;
    localparam int ACC_W     = 48;
    localparam int LEN_W     = 19;

    localparam logic [T_W-1:0]   ONE_Q24  = T_W'(1) << 24;
    localparam logic [ACC_W-1:0] HALF_Q24 = ACC_W'(1) << 23;

    typedef enum logic [1:0] {
        REG_DENSITY = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_THIN    = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CH_X,
        ST_CH_Y,
        ST_CH_SUM,
        ST_CH_SQ,
        ST_PREC,
        ST_PREC_DIV,
        ST_STEP_WAIT,
        ST_PT_T,
        ST_PT_T2,
        ST_PT_T3,
        ST_PT_C1,
        ST_PT_C2,
        ST_PT_C3,
        ST_PT_RES,
        ST_V_X,
        ST_V_Y,
        ST_V_SUM,
        ST_V_SQ,
        ST_NX_DIV,
        ST_NX_WAIT,
        ST_NY_DIV,
        ST_NY_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic signed [CRD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [CRD_W-1:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[CRD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/bst_mul.sv
`timescale 1ns / 1ps

module bst_mul (
    input  logic                                aclk,
    input  logic signed [bst_pkg::MUL_W-1:0]    a,
    input  logic signed [bst_pkg::MUL_W-1:0]    b,
    output logic signed [bst_pkg::PRD_W-1:0]    p
);
    import bst_pkg::*;

    logic signed [PRD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: rtl/bst_isqrt.sv
`timescale 1ns / 1ps

module bst_isqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bst_pkg::SQ_IN_W-1:0]      radicand,
    output logic                             done,
    output logic [bst_pkg::ROOT_W-1:0]       root
);
    import bst_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SQ_IN_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ROOT_W+1:0]  rem_sh;
    logic [ROOT_W+1:0]  trial;

    // Two radicand bits enter the partial remainder per cycle; one root bit leaves.
    always_comb begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[SQ_IN_W-1:SQ_IN_W-2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/bst_div.sv
`timescale 1ns / 1ps

module bst_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bst_pkg::DIV_NUM_W-1:0]    num,
    input  logic [bst_pkg::DIV_DEN_W-1:0]    den,
    output logic                             done,
    output logic [bst_pkg::DIV_NUM_W-1:0]    quot
);
    import bst_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   rem_sh;

    // Restoring division: the dividend shifts out the top while quotient bits fill the bottom.
    always_comb begin
        rem_sh    = {rem_reg, q_reg[DIV_NUM_W-1]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = DIV_DEN_W'(rem_sh - {1'b0, den_reg});
                q_next   = {q_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIV_DEN_W-1:0];
                q_next   = {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/cubic_bezier_stroke_tessellator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Contents
// s_        in         s_valid / s_ready   one curve: four control points p0..p3
// m_        out        m_valid / m_ready   one point (thin) or vertex pair (thick), m_last
// apb       in         psel/penable/pready step_density, stroke_width, thin_mode
//
// One curve at a time; s_ready is high only while the sequencer is idle.
// Setup after acceptance computes the three chord roots, then the step count and its
// reciprocal. Each thick step also waits for a square root and two divides to form
// the normal; a zero step vector skips them, and a closing thick pair follows the
// last step.
// A stalled m_ready holds the sequencer in its emit state. Reset is synchronous.

module cubic_bezier_stroke_tessellator_unit #(
    parameter int MAX_SEGMENTS = 32,
    parameter int FRAC_BITS    = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p0_x,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p0_y,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p1_x,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p1_y,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p2_x,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p2_y,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p3_x,
    input  logic signed [bst_pkg::CRD_W-1:0]   s_p3_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bst_pkg::CRD_W-1:0]   m_out_a_x,
    output logic signed [bst_pkg::CRD_W-1:0]   m_out_a_y,
    output logic signed [bst_pkg::CRD_W-1:0]   m_out_b_x,
    output logic signed [bst_pkg::CRD_W-1:0]   m_out_b_y,
    output logic                               m_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bst_pkg::*;

    localparam int F_W      = $clog2(MAX_SEGMENTS + 2);
    localparam int PREC_CAP = MAX_SEGMENTS * 256;
    localparam int PREC_W   = $clog2(PREC_CAP + 1);

    state_t state_reg, state_next;

    logic [15:0] dens_reg, dens_next;
    logic [11:0] width_reg, width_next;
    logic        thin_reg, thin_next;

    logic signed [CRD_W-1:0]  p_reg [8];
    logic signed [CRD_W-1:0]  p_next [8];
    logic signed [COEF_W-1:0] c1_reg [2], c1_next [2];
    logic signed [COEF_W-1:0] c2_reg [2], c2_next [2];
    logic signed [COEF_W-1:0] c3_reg [2], c3_next [2];
    logic signed [CRD_W-1:0]  pt_reg [2], pt_next [2];
    logic signed [CRD_W-1:0]  prev_reg [2], prev_next [2];
    logic signed [CRD_W-1:0]  nrm_reg [2], nrm_next [2];

    logic [1:0]              seg_reg, seg_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [T_W-1:0]          step_reg, step_next;
    logic [F_W-1:0]          limit_reg, limit_next;
    logic [F_W-1:0]          f_reg, f_next;
    logic [T_W-1:0]          t_reg, t_next;
    logic [T_W-1:0]          t2_reg, t2_next;
    logic [T_W-1:0]          t3_reg, t3_next;
    logic                    axis_reg, axis_next;
    logic                    final_reg, final_next;
    logic [DIV_DEN_W-1:0]    den_reg, den_next;
    logic                    neg_reg, neg_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [CRD_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [CRD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic                    last_reg, last_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] mul_q;
    logic                    sq_start, sq_done;
    logic [SQ_IN_W-1:0]      sq_in;
    logic [ROOT_W-1:0]       sq_root;
    logic                    dv_start, dv_done;
    logic [DIV_NUM_W-1:0]    dv_num, dv_q;
    logic [DIV_DEN_W-1:0]    dv_den;

    logic                    s_acc, cfg_wr, out_free, at_limit, v_zero;
    logic signed [CRD_W:0]   dx, dy, vx, vy;
    logic signed [CRD_W+1:0] nvy;
    logic signed [ACC_W-1:0] sq_sum, s_sum, rnd, qv;
    logic [PRD_W-1:0]        prec_full, num_abs;
    logic [PREC_W-1:0]       prec_c;
    logic [T_W-1:0]          t_cl, t2_cl, t3_cl;
    logic signed [CRD_W-1:0] sp [8];

    bst_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_q));

    bst_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(sq_in),
        .done(sq_done), .root(sq_root)
    );

    bst_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num), .den(dv_den),
        .done(dv_done), .quot(dv_q)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign at_limit  = (f_reg == limit_reg);
    assign m_valid   = m_valid_reg;
    assign m_out_a_x = ax_reg;
    assign m_out_a_y = ay_reg;
    assign m_out_b_x = bx_reg;
    assign m_out_b_y = by_reg;
    assign m_last    = last_reg;

    assign sp[0] = s_p0_x;
    assign sp[1] = s_p0_y;
    assign sp[2] = s_p1_x;
    assign sp[3] = s_p1_y;
    assign sp[4] = s_p2_x;
    assign sp[5] = s_p2_y;
    assign sp[6] = s_p3_x;
    assign sp[7] = s_p3_y;

    always_comb begin
        case (cfg_idx_t'(paddr[3:2]))
            REG_DENSITY: prdata = 32'(dens_reg);
            REG_WIDTH:   prdata = 32'(width_reg);
            REG_THIN:    prdata = 32'(thin_reg);
            default:     prdata = '0;
        endcase
    end

    // Shared arithmetic terms.
    always_comb begin
        case (seg_reg)
            2'd0: begin
                dx = (CRD_W+1)'(p_reg[2]) - (CRD_W+1)'(p_reg[0]);
                dy = (CRD_W+1)'(p_reg[3]) - (CRD_W+1)'(p_reg[1]);
            end
            2'd1: begin
                dx = (CRD_W+1)'(p_reg[4]) - (CRD_W+1)'(p_reg[2]);
                dy = (CRD_W+1)'(p_reg[5]) - (CRD_W+1)'(p_reg[3]);
            end
            default: begin
                dx = (CRD_W+1)'(p_reg[6]) - (CRD_W+1)'(p_reg[4]);
                dy = (CRD_W+1)'(p_reg[7]) - (CRD_W+1)'(p_reg[5]);
            end
        endcase
        vx     = (CRD_W+1)'(pt_reg[0]) - (CRD_W+1)'(prev_reg[0]);
        vy     = (CRD_W+1)'(pt_reg[1]) - (CRD_W+1)'(prev_reg[1]);
        nvy    = -((CRD_W+2)'(vy));
        v_zero = (vx == '0) && (vy == '0);
        sq_sum = acc_reg + ACC_W'(mul_q);
        s_sum  = acc_reg + ACC_W'(mul_q);
        // Arithmetic shift gives the floor, so adding one half rounds half up.
        rnd    = (s_sum + $signed(HALF_Q24)) >>> 24;

        prec_full = PRD_W'(mul_q) >> FRAC_BITS;
        if (prec_full > PRD_W'(PREC_CAP)) begin
            prec_c = PREC_W'(PREC_CAP);
        end else if (prec_full < PRD_W'(256)) begin
            prec_c = PREC_W'(256);
        end else begin
            prec_c = prec_full[PREC_W-1:0];
        end

        t_cl  = (mul_q > PRD_W'(ONE_Q24)) ? ONE_Q24 : mul_q[T_W-1:0];
        t2_cl = ((mul_q >>> 24) > PRD_W'(ONE_Q24)) ? ONE_Q24 : mul_q[T_W+23:24];
        t3_cl = t2_cl;

        num_abs = mul_q[PRD_W-1] ? PRD_W'(-mul_q) : PRD_W'(mul_q);
        qv      = neg_reg ? -ACC_W'({1'b0, dv_q}) : ACC_W'({1'b0, dv_q});
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_acc && (width_reg != '0)) state_next = ST_CH_X;
            ST_CH_X:      state_next = ST_CH_Y;
            ST_CH_Y:      state_next = ST_CH_SUM;
            ST_CH_SUM:    state_next = ST_CH_SQ;
            ST_CH_SQ:     if (sq_done) state_next = (seg_reg == 2'd2) ? ST_PREC : ST_CH_X;
            ST_PREC:      state_next = ST_PREC_DIV;
            ST_PREC_DIV:  state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: if (dv_done) state_next = ST_PT_T;
            ST_PT_T:      state_next = ST_PT_T2;
            ST_PT_T2:     state_next = ST_PT_T3;
            ST_PT_T3:     state_next = ST_PT_C1;
            ST_PT_C1:     state_next = ST_PT_C2;
            ST_PT_C2:     state_next = ST_PT_C3;
            ST_PT_C3:     state_next = ST_PT_RES;
            ST_PT_RES: begin
                if (!axis_reg) begin
                    state_next = ST_PT_C1;
                end else begin
                    state_next = thin_reg ? ST_EMIT : ST_V_X;
                end
            end
            ST_V_X:       state_next = v_zero ? ST_EMIT : ST_V_Y;
            ST_V_Y:       state_next = ST_V_SUM;
            ST_V_SUM:     state_next = ST_V_SQ;
            ST_V_SQ:      if (sq_done) state_next = ST_NX_DIV;
            ST_NX_DIV:    state_next = ST_NX_WAIT;
            ST_NX_WAIT:   if (dv_done) state_next = ST_NY_DIV;
            ST_NY_DIV:    state_next = ST_NY_WAIT;
            ST_NY_WAIT:   if (dv_done) state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (!thin_reg && final_reg) begin
                        state_next = ST_IDLE;
                    end else if (at_limit) begin
                        state_next = thin_reg ? ST_IDLE : ST_EMIT;
                    end else begin
                        state_next = ST_PT_T;
                    end
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier and starts of the iterative units.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        sq_start = 1'b0;
        sq_in    = SQ_IN_W'(sq_sum);
        dv_start = 1'b0;
        dv_num   = DIV_NUM_W'(1) << 32;
        dv_den   = DIV_DEN_W'(prec_c);
        case (state_reg)
            ST_CH_X: begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(dx);
            end
            ST_CH_Y: begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(dy);
            end
            ST_CH_SUM: sq_start = 1'b1;
            ST_PREC: begin
                mul_a = MUL_W'($signed({1'b0, len_reg}));
                mul_b = MUL_W'($signed({1'b0, dens_reg}));
            end
            ST_PREC_DIV: dv_start = 1'b1;
            ST_PT_T: begin
                mul_a = MUL_W'($signed({1'b0, f_reg}));
                mul_b = MUL_W'($signed({1'b0, step_reg}));
            end
            ST_PT_T2: begin
                mul_a = MUL_W'($signed({1'b0, t_cl}));
                mul_b = MUL_W'($signed({1'b0, t_cl}));
            end
            ST_PT_T3: begin
                mul_a = MUL_W'($signed({1'b0, t2_cl}));
                mul_b = MUL_W'($signed({1'b0, t_reg}));
            end
            ST_PT_C1: begin
                mul_a = MUL_W'($signed({1'b0, t_reg}));
                mul_b = MUL_W'(c1_reg[axis_reg]);
            end
            ST_PT_C2: begin
                mul_a = MUL_W'($signed({1'b0, t2_reg}));
                mul_b = MUL_W'(c2_reg[axis_reg]);
            end
            ST_PT_C3: begin
                mul_a = MUL_W'($signed({1'b0, t3_reg}));
                mul_b = MUL_W'(c3_reg[axis_reg]);
            end
            ST_V_X: begin
                mul_a = MUL_W'(vx);
                mul_b = MUL_W'(vx);
            end
            ST_V_Y: begin
                mul_a = MUL_W'(vy);
                mul_b = MUL_W'(vy);
            end
            ST_V_SUM: begin
                sq_start = 1'b1;
                sq_in    = SQ_IN_W'(sq_sum) << 16;
            end
            ST_V_SQ: begin
                mul_a = MUL_W'(nvy);
                mul_b = MUL_W'($signed({1'b0, width_reg}));
            end
            ST_NX_DIV, ST_NY_DIV: begin
                dv_start = 1'b1;
                dv_num   = DIV_NUM_W'(num_abs << 8) + DIV_NUM_W'(den_reg >> 1);
                dv_den   = den_reg;
            end
            ST_NX_WAIT: begin
                mul_a = MUL_W'(vx);
                mul_b = MUL_W'($signed({1'b0, width_reg}));
            end
            default: ;
        endcase
    end

    always_comb begin
        dens_next  = dens_reg;
        width_next = width_reg;
        thin_next  = thin_reg;
        if (cfg_wr) begin
            case (cfg_idx_t'(paddr[3:2]))
                REG_DENSITY: dens_next  = pwdata[15:0];
                REG_WIDTH:   width_next = pwdata[11:0];
                REG_THIN:    thin_next  = pwdata[0];
                default: ;
            endcase
        end

        p_next     = p_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        c3_next    = c3_reg;
        pt_next    = pt_reg;
        prev_next  = prev_reg;
        nrm_next   = nrm_reg;
        seg_next   = seg_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        limit_next = limit_reg;
        f_next     = f_reg;
        t_next     = t_reg;
        t2_next    = t2_reg;
        t3_next    = t3_reg;
        axis_next  = axis_reg;
        final_next = final_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;

        m_valid_next = m_valid_reg && !m_ready;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc && (width_reg != '0)) begin
                    for (int i = 0; i < 8; i++) begin
                        p_next[i] = sp[i];
                    end
                    for (int i = 0; i < 2; i++) begin
                        c1_next[i] = (COEF_W'(sp[2+i]) - COEF_W'(sp[i])) * COEF_W'(3);
                        c2_next[i] = (COEF_W'(sp[i]) - (COEF_W'(sp[2+i]) <<< 1)
                                     + COEF_W'(sp[4+i])) * COEF_W'(3);
                        c3_next[i] = COEF_W'(sp[6+i]) - COEF_W'(sp[i])
                                     + (COEF_W'(sp[2+i]) - COEF_W'(sp[4+i])) * COEF_W'(3);
                        prev_next[i] = sp[i];
                        nrm_next[i]  = '0;
                    end
                    seg_next   = '0;
                    len_next   = '0;
                    axis_next  = 1'b0;
                    final_next = 1'b0;
                end
            end
            ST_CH_Y, ST_V_Y: acc_next = ACC_W'(mul_q);
            ST_CH_SQ: begin
                if (sq_done) begin
                    len_next = len_reg + LEN_W'(sq_root);
                    seg_next = seg_reg + 2'd1;
                end
            end
            ST_PREC_DIV: limit_next = F_W'(prec_c >> 8) + F_W'(1);
            ST_STEP_WAIT: begin
                if (dv_done) begin
                    step_next = dv_q[T_W-1:0];
                    f_next    = '0;
                end
            end
            ST_PT_T2: t_next = t_cl;
            ST_PT_T3: t2_next = t2_cl;
            ST_PT_C1: if (!axis_reg) t3_next = t3_cl;
            ST_PT_C2: acc_next = ACC_W'(mul_q);
            ST_PT_C3: acc_next = s_sum;
            ST_PT_RES: begin
                pt_next[axis_reg] = sat16(ACC_W'(p_reg[axis_reg]) + rnd);
                axis_next         = !axis_reg;
            end
            ST_V_X: begin
                if (v_zero) begin
                    nrm_next[0] = '0;
                    nrm_next[1] = '0;
                end
            end
            ST_V_SQ: if (sq_done) den_next = {sq_root, 1'b0};
            ST_NX_DIV, ST_NY_DIV: neg_next = mul_q[PRD_W-1];
            ST_NX_WAIT: if (dv_done) nrm_next[0] = sat16(qv);
            ST_NY_WAIT: if (dv_done) nrm_next[1] = sat16(qv);
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (thin_reg) begin
                        ax_next   = pt_reg[0];
                        ay_next   = pt_reg[1];
                        bx_next   = pt_reg[0];
                        by_next   = pt_reg[1];
                        last_next = at_limit;
                    end else begin
                        ax_next   = sat16(ACC_W'(prev_reg[0]) + ACC_W'(nrm_reg[0]));
                        ay_next   = sat16(ACC_W'(prev_reg[1]) + ACC_W'(nrm_reg[1]));
                        bx_next   = sat16(ACC_W'(prev_reg[0]) - ACC_W'(nrm_reg[0]));
                        by_next   = sat16(ACC_W'(prev_reg[1]) - ACC_W'(nrm_reg[1]));
                        last_next = final_reg;
                    end
                    prev_next = pt_reg;
                    if (at_limit) begin
                        final_next = 1'b1;
                    end else begin
                        f_next = f_reg + F_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dens_reg    <= 16'd256;
            width_reg   <= 12'd16;
            thin_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            seg_reg     <= '0;
            f_reg       <= '0;
            limit_reg   <= '0;
            axis_reg    <= 1'b0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dens_reg    <= dens_next;
            width_reg   <= width_next;
            thin_reg    <= thin_next;
            m_valid_reg <= m_valid_next;
            seg_reg     <= seg_next;
            f_reg       <= f_next;
            limit_reg   <= limit_next;
            axis_reg    <= axis_next;
            final_reg   <= final_next;
        end
        p_reg    <= p_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        c3_reg   <= c3_next;
        pt_reg   <= pt_next;
        prev_reg <= prev_next;
        nrm_reg  <= nrm_next;
        len_reg  <= len_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        t_reg    <= t_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        last_reg <= last_next;
    end

endmodule

// File: test/cubic_bezier_stroke_tessellator_unit_test.sv
`timescale 1ns / 1ps

module cubic_bezier_stroke_tessellator_unit_test;
    import bst_pkg::*;

    localparam int  MAX_SEG     = 32;
    localparam int  FRAC        = 4;
    localparam longint ONE_T    = 64'd1 << 24;
    localparam longint CYCLE_CAP = 8000000;

    typedef logic signed [CRD_W-1:0] crd_t;

    typedef struct {
        crd_t a_x;
        crd_t a_y;
        crd_t b_x;
        crd_t b_y;
        logic last;
    } vertex_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    crd_t s_p0_x, s_p0_y, s_p1_x, s_p1_y, s_p2_x, s_p2_y, s_p3_x, s_p3_y;
    logic m_valid;
    logic m_ready;
    crd_t m_out_a_x, m_out_a_y, m_out_b_x, m_out_b_y;
    logic m_last;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the configuration registers.
    logic [15:0] cur_density;
    logic [11:0] cur_width;
    logic        cur_thin;

    vertex_t expected_vertices[$];
    int      errors;
    int      curves_sent;
    int      thick_curves;
    int      vertices_seen;
    longint  cycles;
    bit      idle_on;
    int      ready_hold;

    cubic_bezier_stroke_tessellator_unit #(
        .MAX_SEGMENTS(MAX_SEG),
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p0_x(s_p0_x), .s_p0_y(s_p0_y), .s_p1_x(s_p1_x), .s_p1_y(s_p1_y),
        .s_p2_x(s_p2_x), .s_p2_y(s_p2_y), .s_p3_x(s_p3_x), .s_p3_y(s_p3_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_a_x(m_out_a_x), .m_out_a_y(m_out_a_y),
        .m_out_b_x(m_out_b_x), .m_out_b_y(m_out_b_y), .m_last(m_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic crd_t clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return crd_t'(v);
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic vertex_t make_pair(longint px, longint py, longint ox, longint oy);
        vertex_t v;
        v.a_x = clip16(px + ox);
        v.a_y = clip16(py + oy);
        v.b_x = clip16(px - ox);
        v.b_y = clip16(py - oy);
        v.last = 1'b0;
        return v;
    endfunction

    // Flattens one curve with the current settings and queues its vertices.
    task automatic flatten_curve(input crd_t crv[8]);
        longint p[8];
        longint c1[2], c2[2], c3[2];
        longint unsigned len_sum, prec, step;
        longint dx, dy, t, t2, t3, s, vx, vy, lq;
        longint pt[2], prev[2], ofs[2];
        int lim, first;
        vertex_t v;
        if (cur_width == 0) return;
        for (int i = 0; i < 8; i++) p[i] = crv[i];
        len_sum = 0;
        for (int i = 0; i < 3; i++) begin
            dx = p[2*i+2] - p[2*i];
            dy = p[2*i+3] - p[2*i+1];
            len_sum += int_root(dx*dx + dy*dy);
        end
        prec = (longint'(cur_density) * len_sum) >> FRAC;
        if (prec > (MAX_SEG << 8)) prec = MAX_SEG << 8;
        if (prec < 256) prec = 256;
        step = (64'd1 << 32) / prec;
        lim = int'(prec >> 8) + 1;
        for (int i = 0; i < 2; i++) begin
            c1[i] = 3 * (p[2+i] - p[i]);
            c2[i] = 3 * p[i] - 6 * p[2+i] + 3 * p[4+i];
            c3[i] = -p[i] + 3 * p[2+i] - 3 * p[4+i] + p[6+i];
        end
        prev[0] = p[0];
        prev[1] = p[1];
        ofs[0] = 0;
        ofs[1] = 0;
        first = expected_vertices.size();
        for (int f = 0; f <= lim; f++) begin
            t = f * longint'(step);
            if (t > ONE_T) t = ONE_T;
            t2 = (t * t) >>> 24;
            if (t2 > ONE_T) t2 = ONE_T;
            t3 = (t2 * t) >>> 24;
            if (t3 > ONE_T) t3 = ONE_T;
            for (int i = 0; i < 2; i++) begin
                s = t * c1[i] + t2 * c2[i] + t3 * c3[i];
                pt[i] = clip16(p[i] + ((s + ONE_T / 2) >>> 24));
            end
            if (cur_thin) begin
                v = make_pair(pt[0], pt[1], 0, 0);
            end else begin
                vx = pt[0] - prev[0];
                vy = pt[1] - prev[1];
                if (vx != 0 || vy != 0) begin
                    lq = int_root((vx*vx + vy*vy) << 16);
                    ofs[0] = clip16(round_div(-vy * cur_width * 256, 2 * lq));
                    ofs[1] = clip16(round_div(vx * cur_width * 256, 2 * lq));
                end else begin
                    ofs[0] = 0;
                    ofs[1] = 0;
                end
                v = make_pair(prev[0], prev[1], ofs[0], ofs[1]);
            end
            expected_vertices.push_back(v);
            prev[0] = pt[0];
            prev[1] = pt[1];
        end
        if (!cur_thin) expected_vertices.push_back(make_pair(prev[0], prev[1], ofs[0], ofs[1]));
        expected_vertices[expected_vertices.size()-1].last = 1'b1;
        if (!cur_thin) thick_curves++;
        if (expected_vertices.size() < first) errors++;
    endtask

    // Presents one curve request and predicts its vertices once accepted.
    task automatic send_curve(input crd_t crv[8]);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_p0_x <= crv[0];
        s_p0_y <= crv[1];
        s_p1_x <= crv[2];
        s_p1_y <= crv[3];
        s_p2_x <= crv[4];
        s_p2_y <= crv[5];
        s_p3_x <= crv[6];
        s_p3_y <= crv[7];
        do @(posedge aclk); while (!s_ready);
        flatten_curve(crv);
        curves_sent++;
    endtask

    task automatic send_points(input int x0, y0, x1, y1, x2, y2, x3, y3);
        crd_t crv[8];
        crv = '{crd_t'(x0), crd_t'(y0), crd_t'(x1), crd_t'(y1),
                crd_t'(x2), crd_t'(y2), crd_t'(x3), crd_t'(y3)};
        send_curve(crv);
    endtask

    // Mostly short curves around a random base, now and then a full-range point.
    task automatic send_random_curve();
        crd_t crv[8];
        crd_t base_x, base_y;
        base_x = crd_t'($urandom);
        base_y = crd_t'($urandom);
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                crv[2*i] = crd_t'($urandom);
                crv[2*i+1] = crd_t'($urandom);
            end else begin
                crv[2*i] = base_x + crd_t'($urandom_range(0, 62)) - 16'sd31;
                crv[2*i+1] = base_y + crd_t'($urandom_range(0, 62)) - 16'sd31;
            end
        end
        send_curve(crv);
    endtask

    // Waits until every vertex has come and the sequencer is idle again.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_vertices.size() != 0);
        do @(posedge aclk); while (!s_ready);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        // An accepted request must not be offered again while the port is in use.
        s_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DENSITY: cur_density = value[15:0];
            REG_WIDTH:   cur_width = value[11:0];
            REG_THIN:    cur_thin = value[0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input int density, input int width, input bit thin);
        write_reg(REG_DENSITY, density);
        write_reg(REG_WIDTH, width);
        write_reg(REG_THIN, thin);
    endtask

    task automatic test_reset_settings();
        send_points(0, 0, 0, 0, 0, 0, 0, 0);
        send_points(0, 0, 160, 0, 320, 0, 480, 0);
        send_points(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_points(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_points(-32768, 0, -32768, 32767, 32767, -32768, 32767, 0);
        wait_idle();
    endtask

    task automatic test_thick_strips();
        configure(256, 16, 1'b0);
        send_points(0, 0, 0, 0, 0, 0, 0, 0);
        send_points(0, 0, 64, 64, 128, -64, 256, 0);
        send_points(100, 100, 100, 100, 100, 100, 100, 164);
        wait_idle();
        write_reg(REG_WIDTH, 4095);
        send_points(32767, 32767, 32700, 32767, 32767, 32700, 32600, 32600);
        send_points(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
        send_points(-32700, 32700, -32768, 32767, -32600, 32767, -32768, 32600);
        wait_idle();
    endtask

    task automatic test_zero_width();
        configure(256, 0, 1'b0);
        send_points(0, 0, 64, 64, 128, 0, 256, 0);
        send_points(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        write_reg(REG_THIN, 1);
        send_points(5, 5, 40, 9, 80, -7, 120, 3);
        wait_idle();
        // A zero-width curve that was still in flight must not leak out here.
        repeat (300) @(posedge aclk);
    endtask

    task automatic test_density_extremes();
        configure(65535, 24, 1'b1);
        send_points(0, 0, 1, 0, 2, 0, 3, 1);
        send_points(0, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
        write_reg(REG_DENSITY, 1);
        send_points(-32768, 0, 32767, 0, -32768, 0, 32767, 0);
        wait_idle();
        write_reg(REG_THIN, 0);
        send_points(0, 0, 300, 40, -200, 90, 500, 500);
        wait_idle();
        write_reg(REG_DENSITY, 65535);
        send_points(10, 10, 20, -10, 30, 10, 40, -10);
        wait_idle();
    endtask

    task automatic test_random_phase(input int density, input int width, input bit thin,
                                     input int count, input bit pause_midway);
        configure(density, width, thin);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                // Hold the next request back until the strip so far has drained.
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_vertices.size() != 0);
            end
            send_random_curve();
        end
        wait_idle();
    endtask

    always @(posedge aclk) begin
        vertex_t exp_v;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d vertices outstanding", $time,
                     expected_vertices.size());
            $display("status: fail");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
                errors++;
                $display("%0t: unexpected vertex a=(%0d,%0d) b=(%0d,%0d) last=%0b", $time,
                         m_out_a_x, m_out_a_y, m_out_b_x, m_out_b_y, m_last);
            end else begin
                exp_v = expected_vertices.pop_front();
                if (m_out_a_x !== exp_v.a_x || m_out_a_y !== exp_v.a_y ||
                    m_out_b_x !== exp_v.b_x || m_out_b_y !== exp_v.b_y ||
                    m_last !== exp_v.last) begin
                    errors++;
                    $display("%0t: expected a=(%0d,%0d) b=(%0d,%0d) last=%0b, ",
                             $time, exp_v.a_x, exp_v.a_y, exp_v.b_x, exp_v.b_y, exp_v.last,
                             "got a=(%0d,%0d) b=(%0d,%0d) last=%0b",
                             m_out_a_x, m_out_a_y, m_out_b_x, m_out_b_y, m_last);
                end
            end
        end
    end

    // Random back-pressure on the vertex channel.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            if (ready_hold == 0) m_ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            ready_hold = $urandom_range(1, 17);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_p0_x, s_p0_y, s_p1_x, s_p1_y, s_p2_x, s_p2_y, s_p3_x, s_p3_y} = '0;
        m_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_density = 16'd256;
        cur_width = 12'd16;
        cur_thin = 1'b1;
        errors = 0;
        curves_sent = 0;
        thick_curves = 0;
        vertices_seen = 0;
        cycles = 0;
        ready_hold = 0;
        idle_on = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_thick_strips();
        test_zero_width();
        test_density_extremes();
        test_random_phase(256, 16, 1'b1, 60, 1'b0);
        test_random_phase(65535, 4095, 1'b0, 60, 1'b1);
        test_random_phase(1, 1, 1'b0, 60, 1'b0);
        test_random_phase(512, 100, 1'b1, 60, 1'b0);
        test_random_phase(128, 8, 1'b0, 60, 1'b0);
        test_random_phase(3000, 2000, 1'b0, 60, 1'b0);
        idle_on = 1'b0;
        test_random_phase(256, 40, 1'b0, 30, 1'b0);

        repeat (200) @(posedge aclk);
        $display("Flattened %0d curves (%0d as thick strips) into %0d checked vertices,",
                 curves_sent, thick_curves, vertices_seen);
        $display("across thin, thick and zero-width settings with density and width extremes.");
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d vertices never arrived", errors,
                     expected_vertices.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: cubic_bezier_stroke_tessellator_unit.f
rtl/bst_pkg.sv
rtl/bst_mul.sv
rtl/bst_isqrt.sv
rtl/bst_div.sv
rtl/cubic_bezier_stroke_tessellator_unit.sv
test/cubic_bezier_stroke_tessellator_unit_test.sv
